// File: sv/ame_pkg.sv
// Shared types and constants for the accumulator machine executor.
// Holds operation codes, state machine encodings and the arithmetic unit control struct.
// No dependencies.
`default_nettype none

package ame_pkg;

  localparam int ADDR_BITS  = 10;
  localparam int VALUE_BITS = 32;
  localparam int OP_BITS    = 3;

  typedef enum logic [OP_BITS-1:0] {
    OP_STORE  = 3'd0,
    OP_LOAD   = 3'd1,
    OP_ADD    = 3'd2,
    OP_SUB    = 3'd3,
    OP_MUL    = 3'd4,
    OP_DIV    = 3'd5,
    OP_FINISH = 3'd6
  } opcode_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef enum logic [1:0] {
    AS_IDLE,
    AS_RUN,
    AS_FIX,
    AS_DONE
  } alu_state_t;

  typedef enum logic [2:0] {
    TS_CLEAR,
    TS_IDLE,
    TS_READ,
    TS_EXEC,
    TS_DONE
  } top_state_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctrl_t;

endpackage

`default_nettype wire

// File: sv/ame_mem.sv
// Data memory of the accumulator machine with one write port and one registered read port.
// After reset a clearing pass writes zero to every word, one word per cycle.
// Depends on nothing outside this file.
`default_nettype none

module ame_mem #(
  parameter int MEMORY_WORDS = 256,
  parameter int WORD_BITS    = 32,
  localparam int AW          = $clog2(MEMORY_WORDS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output logic [WORD_BITS-1:0] rd_data,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [WORD_BITS-1:0] wr_data,
  output logic                 busy
);

  logic [WORD_BITS-1:0] mem [MEMORY_WORDS];
  logic [AW-1:0]        clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_cnt <= '0;
    end else if (busy) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == AW'(MEMORY_WORDS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_cnt] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: sv/ame_serial_alu.sv
// Serial arithmetic unit: bit-serial add and subtract, shift-add multiply and
// restoring signed divide, one bit per cycle. Depends on ame_pkg.
`default_nettype none

module ame_serial_alu
  import ame_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  alu_ctrl_t            ctrl,
  input  logic [WORD_BITS-1:0] a,
  input  logic [WORD_BITS-1:0] b,
  output logic [WORD_BITS-1:0] result,
  output logic                 done
);

  localparam int W  = WORD_BITS;
  localparam int CW = $clog2(WORD_BITS);

  alu_state_t     state;
  alu_state_t     state_next;
  alu_op_t        op_r;
  logic [CW-1:0]  cnt;
  logic [W-1:0]   sa;
  logic [W-1:0]   sb;
  logic [W-1:0]   part;
  logic           carry;
  logic           neg;
  logic           sum_bit;
  logic           carry_next;
  logic [W:0]     trial;

  always_comb begin
    state_next = state;
    case (state)
      AS_IDLE: begin
        if (ctrl.start) begin
          state_next = AS_RUN;
        end
      end
      AS_RUN: begin
        if (cnt == '0) begin
          state_next = (op_r == ALU_DIV) ? AS_FIX : AS_DONE;
        end
      end
      AS_FIX:  state_next = AS_DONE;
      AS_DONE: state_next = AS_IDLE;
      default: state_next = AS_IDLE;
    endcase
  end

  always_comb begin
    done   = (state == AS_DONE);
    result = (op_r == ALU_MUL) ? part : sa;
  end

  always_comb begin
    sum_bit    = sa[0] ^ sb[0] ^ carry;
    carry_next = (sa[0] & sb[0]) | (sa[0] & carry) | (sb[0] & carry);
    trial      = {part, sa[W-1]} - {1'b0, sb};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= AS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      AS_IDLE: begin
        if (ctrl.start) begin
          op_r <= ctrl.op;
          cnt  <= CW'(WORD_BITS - 1);
          part <= '0;
          case (ctrl.op)
            ALU_ADD: begin
              sa    <= a;
              sb    <= b;
              carry <= 1'b0;
            end
            ALU_SUB: begin
              sa    <= a;
              sb    <= ~b;
              carry <= 1'b1;
            end
            ALU_MUL: begin
              sa <= a;
              sb <= b;
            end
            default: begin
              sa  <= a[W-1] ? -a : a;
              sb  <= b[W-1] ? -b : b;
              neg <= a[W-1] ^ b[W-1];
            end
          endcase
        end
      end
      AS_RUN: begin
        cnt <= cnt - 1'b1;
        case (op_r)
          ALU_ADD, ALU_SUB: begin
            sa    <= {sum_bit, sa[W-1:1]};
            sb    <= {1'b0, sb[W-1:1]};
            carry <= carry_next;
          end
          ALU_MUL: begin
            part <= {part[W-2:0], 1'b0} + (sb[W-1] ? sa : '0);
            sb   <= {sb[W-2:0], 1'b0};
          end
          default: begin
            part <= trial[W] ? {part[W-2:0], sa[W-1]} : trial[W-1:0];
            sa   <= {sa[W-2:0], ~trial[W]};
          end
        endcase
      end
      AS_FIX: begin
        if (neg) begin
          sa <= -sa;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: sv/accumulator_machine_executor.sv
// Accumulator machine executor: one operation in, one result out per transfer.
// Input channel carries opcode, address and store_value; output channel carries
// accumulator_value and the zero_divisor, bad_address and finished flags.
// Store, load, finish, no-op and out-of-range operations go from the read state
// straight to the done state. Add, subtract, multiply and divide run in the
// serial arithmetic unit, which handles one bit per cycle; divide also passes
// a sign fix step there. The result is then registered in the output register.
// After reset a clearing pass writes zero to all MEMORY_WORDS memory words, one
// per cycle, and in_stall stays high until the pass has ended; the accumulator
// resets to zero.
// The output register holds a result until the receiver takes it. While it is
// full a new operation is still accepted and executed, and it waits only at its
// end for the register to free up when out_stall stays high.
// Depends on ame_pkg, ame_mem and ame_serial_alu.
`default_nettype none

module accumulator_machine_executor
  import ame_pkg::*;
#(
  parameter int MEMORY_WORDS = 256,
  parameter int WORD_BITS    = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [OP_BITS-1:0]           opcode,
  input  logic [ADDR_BITS-1:0]         address,
  input  logic signed [VALUE_BITS-1:0] store_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [VALUE_BITS-1:0] accumulator_value,
  output logic                         zero_divisor,
  output logic                         bad_address,
  output logic                         finished
);

  localparam int AW = $clog2(MEMORY_WORDS);
  localparam int W  = WORD_BITS;

  top_state_t          state;
  top_state_t          state_next;
  logic [OP_BITS-1:0]  op_r;
  logic [AW-1:0]       addr_r;
  logic [W-1:0]        sv_r;
  logic                bad_r;
  logic                fin_r;
  logic                zd_r;
  logic [W-1:0]        acc;
  logic signed [63:0]  sv_ext;
  logic                in_range;

  logic                mem_rd_en;
  logic [W-1:0]        mem_rd_data;
  logic                mem_wr_en;
  logic [W-1:0]        mem_wr_data;
  logic                mem_busy;

  alu_ctrl_t           alu_ctrl;
  logic [W-1:0]        alu_b;
  logic [W-1:0]        alu_result;
  logic                alu_done;

  logic                is_arith;
  logic                word_zero;
  logic                slot_free;

  ame_mem #(
    .MEMORY_WORDS(MEMORY_WORDS),
    .WORD_BITS   (WORD_BITS)
  ) u_mem (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (mem_rd_en),
    .rd_addr(address[AW-1:0]),
    .rd_data(mem_rd_data),
    .wr_en  (mem_wr_en),
    .wr_addr(addr_r),
    .wr_data(mem_wr_data),
    .busy   (mem_busy)
  );

  ame_serial_alu #(
    .WORD_BITS(WORD_BITS)
  ) u_alu (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (alu_ctrl),
    .a     (acc),
    .b     (alu_b),
    .result(alu_result),
    .done  (alu_done)
  );

  always_comb begin
    sv_ext    = 64'(store_value);
    in_range  = ({1'b0, address} < 11'(MEMORY_WORDS));
    word_zero = (mem_rd_data == '0);
    slot_free = !out_valid || !out_stall;
    case (op_r)
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: is_arith = 1'b1;
      default:                        is_arith = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      TS_CLEAR: begin
        if (!mem_busy) begin
          state_next = TS_IDLE;
        end
      end
      TS_IDLE: begin
        if (in_valid) begin
          state_next = TS_READ;
        end
      end
      TS_READ: begin
        state_next = (is_arith && !bad_r) ? TS_EXEC : TS_DONE;
      end
      TS_EXEC: begin
        if (alu_done) begin
          state_next = TS_DONE;
        end
      end
      TS_DONE: begin
        if (slot_free) begin
          state_next = TS_IDLE;
        end
      end
      default: state_next = TS_IDLE;
    endcase
  end

  always_comb begin
    in_stall       = (state != TS_IDLE);
    mem_rd_en      = (state == TS_IDLE) && in_valid;
    mem_wr_en      = 1'b0;
    mem_wr_data    = sv_r;
    alu_ctrl.start = 1'b0;
    alu_ctrl.op    = ALU_ADD;
    alu_b          = mem_rd_data;
    case (op_r)
      OP_SUB:  alu_ctrl.op = ALU_SUB;
      OP_MUL:  alu_ctrl.op = ALU_MUL;
      OP_DIV:  alu_ctrl.op = ALU_DIV;
      default: alu_ctrl.op = ALU_ADD;
    endcase
    if (op_r == OP_DIV && word_zero) begin
      alu_b       = W'(1);
      mem_wr_data = W'(1);
    end
    if (state == TS_READ && !bad_r) begin
      alu_ctrl.start = is_arith;
      mem_wr_en      = (op_r == OP_STORE) || (op_r == OP_DIV && word_zero);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= TS_CLEAR;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == TS_READ && !bad_r && op_r == OP_LOAD) begin
        acc <= mem_rd_data;
      end else if (state == TS_EXEC && alu_done) begin
        acc <= alu_result;
      end
      if (state == TS_DONE && slot_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == TS_IDLE && in_valid) begin
      op_r   <= opcode;
      addr_r <= address[AW-1:0];
      sv_r   <= sv_ext[W-1:0];
      bad_r  <= (opcode <= OP_DIV) && !in_range;
      fin_r  <= (opcode == OP_FINISH);
      zd_r   <= 1'b0;
    end else if (state == TS_READ) begin
      zd_r <= !bad_r && op_r == OP_DIV && word_zero;
    end
    if (state == TS_DONE && slot_free) begin
      accumulator_value <= 32'(acc);
      zero_divisor      <= zd_r;
      bad_address       <= bad_r;
      finished          <= fin_r;
    end
  end

endmodule

`default_nettype wire
